// File: rtl/core/lodh_pkg.sv
// Shared types and constants for the detail-level selector.
package lodh_pkg;

  localparam int DSQ_W      = 48;
  localparam int DIST_W     = 24;
  localparam int LVL_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_RANGES = 5;
  localparam int ROOT_STEPS = 24;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  localparam logic [DSQ_W-1:0]  ROOT_BIT0 = 48'h4000_0000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX  = 24'hFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_UP,
    ST_DOWN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

// File: rtl/core/lodh_isqrt.sv
// Bit-serial 48-bit floor square root, two radicand bits per cycle.
module lodh_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lodh_pkg::DSQ_W-1:0] din,
  output logic [lodh_pkg::DIST_W-1:0] root,
  output lodh_pkg::sq_stat_t         stat
);

  logic [lodh_pkg::DSQ_W-1:0]      x_r, x_nxt;
  logic [lodh_pkg::DSQ_W-1:0]      res_r, res_nxt;
  logic [lodh_pkg::DSQ_W-1:0]      bit_r, bit_nxt;
  logic [lodh_pkg::ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [lodh_pkg::DSQ_W-1:0]      trial;

  assign trial = res_r + bit_r;

  always_comb begin
    x_nxt    = x_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = din;
      res_nxt  = '0;
      bit_nxt  = lodh_pkg::ROOT_BIT0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt   = x_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lodh_pkg::ROOT_CNT_W'(lodh_pkg::ROOT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign root      = res_r[lodh_pkg::DIST_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: rtl/core/lod_level_select_hysteresis.sv
// Top level: detail-level selector with hysteresis around a serial square root.
//
//   channel  direction  beat contents
//   in       input      func, dist_squared
//   out      output     level, changed, has_levels
//   cfg      input      index, data (register write)
//
// Update beat: the accept cycle, the root state (24 root steps, then taking the
// result), then an up and a down step per pass (passes = level moves + 1, at most
// 4*MAX_LEVELS), then loading the output register. Force and no-level beats go from accept to the load.
// Synchronous active-low reset clears the state, the registers and the current level.
// in_ready is high only while idle; a result waiting on out_ready holds the block
// in its final cycle. cfg_ready is always high.
module lod_level_select_hysteresis #(
  parameter int MAX_LEVELS = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [lodh_pkg::DSQ_W-1:0]     in_dist_squared,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lodh_pkg::LVL_W-1:0]     out_level,
  output logic                           out_changed,
  output logic                           out_has_levels,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lodh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lodh_pkg::DIST_W-1:0]    cfg_data
);

  localparam int IDX_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SUM_W    = $clog2(MAX_LEVELS + 1);
  localparam int ITER_MAX = 4 * MAX_LEVELS;
  localparam int ITER_W   = $clog2(ITER_MAX + 1);

  lodh_pkg::state_t                 state_r, state_nxt;
  logic [lodh_pkg::LVL_W-1:0]       lc_r, lc_nxt;
  logic [lodh_pkg::DIST_W-1:0]      hyst_r, hyst_nxt;
  logic [lodh_pkg::DIST_W-1:0]      range_r [lodh_pkg::NUM_RANGES];
  logic [lodh_pkg::DIST_W-1:0]      range_nxt [lodh_pkg::NUM_RANGES];
  logic [lodh_pkg::DIST_W-1:0]      start_r [MAX_LEVELS];
  logic [lodh_pkg::DIST_W-1:0]      start_nxt [MAX_LEVELS];
  logic [lodh_pkg::DIST_W-1:0]      acc_r, acc_nxt;
  logic [SUM_W-1:0]                 sum_idx_r, sum_idx_nxt;
  logic [lodh_pkg::LVL_W-1:0]       cur_r, cur_nxt;
  logic [lodh_pkg::LVL_W-1:0]       curr_r, curr_nxt;
  logic                             chg_r, chg_nxt;
  logic                             has_r, has_nxt;
  logic                             moved_r, moved_nxt;
  logic [ITER_W-1:0]                iter_r, iter_nxt;
  logic [lodh_pkg::DIST_W-1:0]      dist_r, dist_nxt;
  logic                             ov_r, ov_nxt;
  logic [lodh_pkg::LVL_W-1:0]       ol_r, ol_nxt;
  logic                             oc_r, oc_nxt;
  logic                             oh_r, oh_nxt;

  logic [lodh_pkg::LVL_W-1:0]       n_lvl;
  logic [lodh_pkg::LVL_W-1:0]       n_last;
  logic [lodh_pkg::LVL_W-1:0]       lvl_up;
  logic [lodh_pkg::LVL_W-1:0]       rd_lvl;
  logic [IDX_W-1:0]                 rd_idx;
  logic [lodh_pkg::DIST_W-1:0]      rd_start;
  logic [lodh_pkg::DIST_W:0]        thr_up;
  logic [lodh_pkg::DIST_W:0]        acc_sum;
  logic [lodh_pkg::CFG_IDX_W-1:0]   rng_wr;
  logic [lodh_pkg::CFG_IDX_W-1:0]   rng_rd;
  logic                             sq_start;
  logic [lodh_pkg::DIST_W-1:0]      sq_root;
  lodh_pkg::sq_stat_t               sq_stat;

  lodh_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .din   (in_dist_squared),
    .root  (sq_root),
    .stat  (sq_stat)
  );

  assign n_lvl  = (lc_r > lodh_pkg::LVL_W'(MAX_LEVELS)) ? lodh_pkg::LVL_W'(MAX_LEVELS) : lc_r;
  assign n_last = n_lvl - 1'b1;
  assign lvl_up = curr_r + 1'b1;
  assign rd_lvl = (state_r == lodh_pkg::ST_UP) ? lvl_up : curr_r;
  assign rd_idx = (rd_lvl < lodh_pkg::LVL_W'(MAX_LEVELS)) ? IDX_W'(rd_lvl) : '0;
  assign rd_start = start_r[rd_idx];
  assign thr_up = {1'b0, rd_start} + {1'b0, hyst_r};
  assign rng_wr = cfg_index - lodh_pkg::CFG_RANGE_FIRST;
  assign rng_rd = lodh_pkg::CFG_IDX_W'(sum_idx_r - 1'b1);
  assign acc_sum = {1'b0, acc_r} + {1'b0, range_r[rng_rd]};

  assign in_ready  = (state_r == lodh_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign sq_start  = in_valid && in_ready && !in_func && (n_lvl != '0);

  always_comb begin
    lc_nxt   = lc_r;
    hyst_nxt = hyst_r;
    for (int i = 0; i < lodh_pkg::NUM_RANGES; i++) begin
      range_nxt[i] = range_r[i];
    end
    if (cfg_valid) begin
      case (cfg_index)
        lodh_pkg::CFG_LEVEL_COUNT: lc_nxt   = cfg_data[lodh_pkg::LVL_W-1:0];
        lodh_pkg::CFG_HYSTERESIS:  hyst_nxt = cfg_data;
        default: begin
          if (cfg_index inside {[lodh_pkg::CFG_RANGE_FIRST:lodh_pkg::CFG_RANGE_LAST]}) begin
            range_nxt[rng_wr] = cfg_data;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    curr_nxt    = curr_r;
    chg_nxt     = chg_r;
    has_nxt     = has_r;
    moved_nxt   = moved_r;
    iter_nxt    = iter_r;
    dist_nxt    = dist_r;
    acc_nxt     = acc_r;
    sum_idx_nxt = sum_idx_r;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      start_nxt[i] = start_r[i];
    end
    ov_nxt = ov_r;
    ol_nxt = ol_r;
    oc_nxt = oc_r;
    oh_nxt = oh_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      lodh_pkg::ST_IDLE: begin
        if (in_valid) begin
          has_nxt = (n_lvl != '0);
          if (in_func) begin
            chg_nxt   = (cur_r != '0);
            curr_nxt  = '0;
            cur_nxt   = '0;
            state_nxt = lodh_pkg::ST_DONE;
          end else if (n_lvl == '0) begin
            chg_nxt   = 1'b0;
            curr_nxt  = cur_r;
            state_nxt = lodh_pkg::ST_DONE;
          end else begin
            if (cur_r > n_last) begin
              cur_nxt  = n_last;
              curr_nxt = n_last;
            end else begin
              curr_nxt = cur_r;
            end
            start_nxt[0] = '0;
            acc_nxt      = '0;
            sum_idx_nxt  = SUM_W'(1);
            iter_nxt     = '0;
            state_nxt    = lodh_pkg::ST_ROOT;
          end
        end
      end
      lodh_pkg::ST_ROOT: begin
        if (sum_idx_r < SUM_W'(MAX_LEVELS)) begin
          acc_nxt = acc_sum[lodh_pkg::DIST_W] ? lodh_pkg::DIST_MAX
                                              : acc_sum[lodh_pkg::DIST_W-1:0];
          start_nxt[IDX_W'(sum_idx_r)] = acc_nxt;
          sum_idx_nxt = sum_idx_r + 1'b1;
        end
        if (sq_stat.done) begin
          dist_nxt  = sq_root;
          state_nxt = lodh_pkg::ST_UP;
        end
      end
      lodh_pkg::ST_UP: begin
        moved_nxt = 1'b0;
        if ((lvl_up < n_lvl) && ({1'b0, dist_r} >= thr_up)) begin
          curr_nxt  = lvl_up;
          moved_nxt = 1'b1;
        end
        state_nxt = lodh_pkg::ST_DOWN;
      end
      lodh_pkg::ST_DOWN: begin
        if ((curr_r != '0) && (dist_r < rd_start)) begin
          curr_nxt  = curr_r - 1'b1;
          moved_nxt = 1'b1;
        end
        iter_nxt = iter_r + 1'b1;
        if (!moved_nxt || (iter_r == ITER_W'(ITER_MAX - 1))) begin
          chg_nxt   = (curr_nxt != cur_r);
          cur_nxt   = curr_nxt;
          state_nxt = lodh_pkg::ST_DONE;
        end else begin
          state_nxt = lodh_pkg::ST_UP;
        end
      end
      lodh_pkg::ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ol_nxt    = curr_r;
          oc_nxt    = chg_r;
          oh_nxt    = has_r;
          state_nxt = lodh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lodh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lodh_pkg::ST_IDLE;
      lc_r    <= '0;
      hyst_r  <= '0;
      for (int i = 0; i < lodh_pkg::NUM_RANGES; i++) begin
        range_r[i] <= '0;
      end
      cur_r   <= '0;
      ov_r    <= 1'b0;
      iter_r  <= '0;
      curr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      hyst_r  <= hyst_nxt;
      for (int i = 0; i < lodh_pkg::NUM_RANGES; i++) begin
        range_r[i] <= range_nxt[i];
      end
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
      iter_r  <= iter_nxt;
      curr_r  <= curr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chg_r     <= chg_nxt;
    has_r     <= has_nxt;
    moved_r   <= moved_nxt;
    dist_r    <= dist_nxt;
    acc_r     <= acc_nxt;
    sum_idx_r <= sum_idx_nxt;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      start_r[i] <= start_nxt[i];
    end
    ol_r <= ol_nxt;
    oc_r <= oc_nxt;
    oh_r <= oh_nxt;
  end

  assign out_valid      = ov_r;
  assign out_level      = ol_r;
  assign out_changed    = oc_r;
  assign out_has_levels = oh_r;

  a_idle_root_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sq_stat.busy)
    else $error("square-root unit busy while idle");

  a_root_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lodh_pkg::ST_ROOT) |-> (sq_stat.busy || sq_stat.done))
    else $error("root state without a running square root");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == lodh_pkg::ST_UP) || (state_r == lodh_pkg::ST_DOWN)) |-> (curr_r < n_lvl))
    else $error("stepping level outside levels in use");

  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r < lodh_pkg::LVL_W'(MAX_LEVELS))
    else $error("stored level beyond level limit");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r < ITER_W'(ITER_MAX))
    else $error("step pass count overran");

endmodule
